// ===== src/ple_pkg.sv =====
// Shared definitions for the positional list engine.
// Request codes, status codes, field widths and the controller/datapath link types.
// No dependencies.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL          = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_OR_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE         = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic latch;    // capture the request fields, clear the scan index
        logic step;     // advance the scan index
        logic finish;   // apply the operation and load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_find;
        logic scan_done;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/ple_datapath.sv =====
// Datapath of the positional list engine: list cells, count, scan index, result registers.
// Depends on ple_pkg.
`default_nettype none

module ple_datapath #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire ple_pkg::cmd_t                   cmd,
    output ple_pkg::sts_t                        sts,
    input  wire        [ple_pkg::FUNC_W-1:0]     func,
    input  wire signed [ple_pkg::VALUE_W-1:0]    item_value,
    input  wire        [ple_pkg::POS_W-1:0]      item_position,
    output logic signed [ple_pkg::VALUE_W-1:0]   result_value,
    output logic       [ple_pkg::POS_W-1:0]      found_index,
    output logic       [ple_pkg::STATUS_W-1:0]   status,
    output logic       [ple_pkg::POS_W-1:0]      entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PW    = ple_pkg::POS_W;
    localparam int VW    = ple_pkg::VALUE_W;

    logic [ple_pkg::FUNC_W-1:0] func_reg;
    logic signed [VW-1:0]       value_reg;
    logic [PW-1:0]              pos_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           idx_reg;
    logic signed [VW-1:0]       cells_reg [CAPACITY];

    logic [PW-1:0]    count_ext;
    logic [PW-1:0]    ins_pos;
    logic [PW-1:0]    ext_pos;
    logic [IDX_W-1:0] rd_addr;
    logic signed [VW-1:0] cell_rd;
    logic             is_insert;
    logic             is_extract;
    logic             is_find;
    logic             full;
    logic             empty;
    logic             in_range;
    logic             rd_ok;
    logic             do_insert;
    logic             do_extract;

    assign count_ext  = PW'(count_reg);
    assign is_insert  = func_reg == ple_pkg::FUNC_INSERT;
    assign is_extract = func_reg == ple_pkg::FUNC_EXTRACT;
    assign is_find    = func_reg == ple_pkg::FUNC_FIND;
    assign full       = count_reg == CNT_W'(CAPACITY);
    assign empty      = count_reg == '0;
    assign in_range   = idx_reg < count_reg;
    assign rd_ok      = pos_reg < count_ext;
    assign do_insert  = cmd.finish && is_insert && !full;
    assign do_extract = cmd.finish && is_extract && !empty;

    // positions at or past the count fall back to the tail
    assign ins_pos = (pos_reg > count_ext) ? count_ext : pos_reg;
    assign ext_pos = rd_ok ? pos_reg : count_ext - PW'(1);

    // single read port: scan index for find, request position otherwise
    assign rd_addr = is_find ? idx_reg[IDX_W-1:0] : ext_pos[IDX_W-1:0];
    assign cell_rd = cells_reg[rd_addr];

    assign sts.is_find   = is_find;
    assign sts.scan_done = !in_range || (cell_rd == value_reg);

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_extract)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // cell chain: cells from the position on shift toward or away from the tail together
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (do_insert)
            begin
                if (PW'(i) == ins_pos)
                begin
                    cells_reg[i] <= value_reg;
                end
                else if (i > 0 && PW'(i) > ins_pos && PW'(i) <= count_ext)
                begin
                    cells_reg[i] <= cells_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_extract)
            begin
                if (i < CAPACITY - 1 && PW'(i) >= ext_pos && PW'(i + 1) < count_ext)
                begin
                    cells_reg[i] <= cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.latch)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= func;
            value_reg <= item_value;
            pos_reg   <= item_position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_value <= '0;
            found_index  <= '0;
            status       <= ple_pkg::ST_OK;
            entry_count  <= PW'(count_next);
            case (func_reg)
                ple_pkg::FUNC_INSERT:
                begin
                    if (full)
                    begin
                        status <= ple_pkg::ST_FULL;
                    end
                end
                ple_pkg::FUNC_EXTRACT:
                begin
                    if (empty)
                    begin
                        status <= ple_pkg::ST_EMPTY_OR_MISS;
                    end
                    else
                    begin
                        result_value <= cell_rd;
                    end
                end
                ple_pkg::FUNC_FIND:
                begin
                    // scan stops on the first match, so a hit is an index below the count
                    if (in_range)
                    begin
                        found_index <= PW'(idx_reg);
                    end
                    else
                    begin
                        status <= ple_pkg::ST_EMPTY_OR_MISS;
                    end
                end
                default:
                begin
                    if (rd_ok)
                    begin
                        result_value <= cell_rd;
                    end
                    else
                    begin
                        status       <= ple_pkg::ST_RANGE;
                        result_value <= '1;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/ple_ctrl.sv =====
// Controller of the positional list engine: request/result handshakes and the find scan.
// Depends on ple_pkg.
`default_nettype none

module ple_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    input  wire ple_pkg::sts_t  sts,
    output ple_pkg::cmd_t       cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WORK = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;
    logic ready_to_finish;

    // result register is free when empty or being taken this cycle
    assign slot_free       = !out_valid_reg || !rsp_stall;
    assign ready_to_finish = !sts.is_find || sts.scan_done;

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (!ready_to_finish)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/positional_list_engine.sv =====
// Positional list engine: bounded ordered list with insert, extract, find and read.
// Usage:
//   Request channel (req_valid/req_stall) carries func, item_value, item_position;
//   a transfer happens on a clock edge with req_valid high and req_stall low.
//   Result channel (rsp_valid/rsp_stall) carries result_value, found_index, status
//   and entry_count; exactly one result per request, in request order.
//   Insert, extract and read: the request fields are latched on the transfer, the
//   result register is loaded from the work state, and then the next request is taken.
//   Find: the datapath compares one cell per cycle from position 0 through the
//   single cell read port until a match or the entry count (a miss); the result
//   is then loaded and the next request taken as for the other requests.
//   One request is in flight at a time; the result register lets the next
//   request be taken while a result is still waiting on a stalled receiver.
//   If the receiver stalls, the result holds and the block stops after one more
//   request, waiting to load its result.
//   Reset (rst_n, asynchronous, active low) empties the list; cell contents are
//   not cleared and are never read before being written.
// Depends on ple_pkg, ple_ctrl, ple_datapath.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 req_valid,
    output logic                                req_stall,
    input  wire        [ple_pkg::FUNC_W-1:0]    func,
    input  wire signed [ple_pkg::VALUE_W-1:0]   item_value,
    input  wire        [ple_pkg::POS_W-1:0]     item_position,
    output logic                                rsp_valid,
    input  wire                                 rsp_stall,
    output logic signed [ple_pkg::VALUE_W-1:0]  result_value,
    output logic       [ple_pkg::POS_W-1:0]     found_index,
    output logic       [ple_pkg::STATUS_W-1:0]  status,
    output logic       [ple_pkg::POS_W-1:0]     entry_count
);

    ple_pkg::cmd_t cmd;
    ple_pkg::sts_t sts;

    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .item_value    (item_value),
        .item_position (item_position),
        .result_value  (result_value),
        .found_index   (found_index),
        .status        (status),
        .entry_count   (entry_count)
    );

    // one request in flight: a request transfer is followed by a stalled cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= ple_pkg::POS_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ple_pkg::ST_FULL |-> entry_count == ple_pkg::POS_W'(CAPACITY))
        else $error("full status with list not full");

    a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ple_pkg::ST_RANGE |-> result_value == -32'sd1)
        else $error("out-of-range read without all-ones value");

endmodule

`default_nettype wire

// ===== dv/ple_checker.sv =====
// Checker for the positional list engine: watches both channels, predicts each result
// and compares it field by field with what the block returns.
// Depends on ple_pkg.
`default_nettype none

module ple_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 req_valid,
    input  wire                                 req_stall,
    input  wire        [ple_pkg::FUNC_W-1:0]    func,
    input  wire signed [ple_pkg::VALUE_W-1:0]   item_value,
    input  wire        [ple_pkg::POS_W-1:0]     item_position,
    input  wire                                 rsp_valid,
    input  wire                                 rsp_stall,
    input  wire signed [ple_pkg::VALUE_W-1:0]   result_value,
    input  wire        [ple_pkg::POS_W-1:0]     found_index,
    input  wire        [ple_pkg::STATUS_W-1:0]  status,
    input  wire        [ple_pkg::POS_W-1:0]     entry_count,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int CAPACITY = ple_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic signed [ple_pkg::VALUE_W-1:0] value;
        logic [ple_pkg::POS_W-1:0]          index;
        logic [ple_pkg::STATUS_W-1:0]       code;
        logic [ple_pkg::POS_W-1:0]          count;
    } list_result_t;

    logic signed [ple_pkg::VALUE_W-1:0] shadow_cells [CAPACITY];
    int                                 shadow_count;
    list_result_t                       awaited_results [$];
    list_result_t                       oldest;

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic list_result_t apply_request(logic [ple_pkg::FUNC_W-1:0] f,
                                                   logic signed [ple_pkg::VALUE_W-1:0] v,
                                                   logic [ple_pkg::POS_W-1:0] p);
        list_result_t r;
        int           pos;
        int           i;
        bit           hit;
        r = '0;
        r.code = ple_pkg::ST_OK;
        pos = int'(p);
        hit = 1'b0;
        case (f)
            ple_pkg::FUNC_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    r.code = ple_pkg::ST_FULL;
                else
                begin
                    if (pos > shadow_count)
                        pos = shadow_count;
                    for (i = shadow_count; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = v;
                    shadow_count++;
                end
            end
            ple_pkg::FUNC_EXTRACT:
            begin
                if (shadow_count == 0)
                    r.code = ple_pkg::ST_EMPTY_OR_MISS;
                else
                begin
                    if (pos >= shadow_count)
                        pos = shadow_count - 1;
                    r.value = shadow_cells[pos];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
            end
            ple_pkg::FUNC_FIND:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_cells[i] == v)
                    begin
                        r.index = ple_pkg::POS_W'(i);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    r.code = ple_pkg::ST_EMPTY_OR_MISS;
            end
            default:
            begin
                if (pos < shadow_count)
                    r.value = shadow_cells[pos];
                else
                begin
                    r.code = ple_pkg::ST_RANGE;
                    r.value = -1;
                end
            end
        endcase
        r.count = ple_pkg::POS_W'(shadow_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_results.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                awaited_results.push_back(apply_request(func, item_value, item_position));
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, expected none actual %h",
                             $time, result_value);
                    fail_count++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    check_field("result_value", oldest.value, result_value);
                    check_field("found_index", 32'(oldest.index), 32'(found_index));
                    check_field("status", 32'(oldest.code), 32'(status));
                    check_field("entry_count", 32'(oldest.count), 32'(entry_count));
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Top of the positional list engine testbench: clock, reset, request stimulus,
// receiver stall and the verdict. Checking is done by ple_checker.
// Depends on ple_pkg, ple_checker and positional_list_engine.
`default_nettype none

module testbench;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    logic        [ple_pkg::FUNC_W-1:0]   func = ple_pkg::FUNC_INSERT;
    logic signed [ple_pkg::VALUE_W-1:0]  item_value = '0;
    logic        [ple_pkg::POS_W-1:0]    item_position = '0;
    logic                                rsp_valid;
    logic                                rsp_stall = 1'b0;
    logic signed [ple_pkg::VALUE_W-1:0]  result_value;
    logic        [ple_pkg::POS_W-1:0]    found_index;
    logic        [ple_pkg::STATUS_W-1:0] status;
    logic        [ple_pkg::POS_W-1:0]    entry_count;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int cycle_count = 0;

    positional_list_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .item_value    (item_value),
        .item_position (item_position),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .result_value  (result_value),
        .found_index   (found_index),
        .status        (status),
        .entry_count   (entry_count)
    );

    ple_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .item_value    (item_value),
        .item_position (item_position),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .result_value  (result_value),
        .found_index   (found_index),
        .status        (status),
        .entry_count   (entry_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAIL positional_list_engine");
                $finish;
            end
        end
    end

    // Receiver: random stall, plus a long counted hold-off on request.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Offers one request, idling first at the current rate; returns once it transfers.
    task automatic send_request(input logic [ple_pkg::FUNC_W-1:0] f,
                                input logic signed [ple_pkg::VALUE_W-1:0] v,
                                input logic [ple_pkg::POS_W-1:0] p);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= f;
        item_value <= v;
        item_position <= p;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
    endtask

    function automatic logic [ple_pkg::FUNC_W-1:0] pick_func(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling)
            return (r < 60) ? ple_pkg::FUNC_INSERT : (r < 75) ? ple_pkg::FUNC_EXTRACT :
                   (r < 88) ? ple_pkg::FUNC_FIND : ple_pkg::FUNC_READ;
        return (r < 15) ? ple_pkg::FUNC_INSERT : (r < 62) ? ple_pkg::FUNC_EXTRACT :
               (r < 80) ? ple_pkg::FUNC_FIND : ple_pkg::FUNC_READ;
    endfunction

    initial
    begin
        logic signed [ple_pkg::VALUE_W-1:0] corner_vals [4];
        logic signed [ple_pkg::VALUE_W-1:0] recent_value;
        logic signed [ple_pkg::VALUE_W-1:0] v;
        logic        [ple_pkg::POS_W-1:0]   p;
        logic        [ple_pkg::FUNC_W-1:0]  f;
        int                                 r;
        int                                 phase;
        corner_vals[0] = 32'sh7fff_ffff;
        corner_vals[1] = 32'sh8000_0000;
        corner_vals[2] = -1;
        corner_vals[3] = 0;
        recent_value = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list cases, fill to capacity, full insert, find/read/extract corners
        send_request(ple_pkg::FUNC_READ, 0, 0);
        send_request(ple_pkg::FUNC_EXTRACT, 0, 0);
        send_request(ple_pkg::FUNC_FIND, 0, 0);
        for (int i = 0; i < ple_pkg::CAPACITY_DEF; i++)
        begin
            v = (i < 4) ? corner_vals[i] : (i % 3);
            p = (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd255 : ple_pkg::POS_W'(i / 2);
            send_request(ple_pkg::FUNC_INSERT, v, p);
        end
        send_request(ple_pkg::FUNC_INSERT, 123, 3);
        send_request(ple_pkg::FUNC_FIND, 2, 0);
        send_request(ple_pkg::FUNC_FIND, 32'sh8000_0000, 0);
        send_request(ple_pkg::FUNC_FIND, 32'sh1234_5678, 0);
        send_request(ple_pkg::FUNC_READ, 0, 0);
        send_request(ple_pkg::FUNC_READ, 0, 15);
        send_request(ple_pkg::FUNC_READ, 0, 255);
        send_request(ple_pkg::FUNC_EXTRACT, 0, 255);
        send_request(ple_pkg::FUNC_EXTRACT, 0, 0);
        send_request(ple_pkg::FUNC_EXTRACT, 0, 7);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase = (n / 100) % 4;
            if (n >= 700 && n < 740)
                phase = 0;
            if (n == 700)
                hold_requests++;
            case (phase)
                0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin sender_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin sender_idle_pct = 15; rx_stall_pct = 15; end
            endcase

            // alternate filling and draining stretches so both full and empty are visited
            f = pick_func(((n / 40) % 2) == 0);

            r = $urandom_range(0, 9);
            if (r < 5)
                v = $signed($urandom_range(0, 7)) - 4;
            else if (r < 7)
                v = $urandom;
            else if (r == 7)
                v = 32'sh8000_0000;
            else if (r == 8)
                v = 32'sh7fff_ffff;
            else
                v = recent_value;

            r = $urandom_range(0, 9);
            if (r < 6)
                p = ple_pkg::POS_W'($urandom_range(0, 17));
            else if (r < 8)
                p = ple_pkg::POS_W'($urandom_range(0, 255));
            else
                p = (r == 8) ? 8'd255 : 8'd16;

            if (f == ple_pkg::FUNC_INSERT)
                recent_value = v;
            send_request(f, v, p);
        end
        req_valid <= 1'b0;
        sender_idle_pct = 0;
        rx_stall_pct = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS positional_list_engine");
        else
            $display("FAIL positional_list_engine");
        $finish;
    end

endmodule

`default_nettype wire
